/* rtl/scan_breakpoint_segmenter_defines.svh */
// assertion macros for the scan breakpoint segmenter
`ifndef SCAN_BREAKPOINT_SEGMENTER_DEFINES_SVH
`define SCAN_BREAKPOINT_SEGMENTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sbs_pkg.sv */
// shared types, constants and the distance check of the scan segmenter
`default_nettype none

package sbs_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned IDX_OUT_W = 11;
	localparam int unsigned THR_W = 2 * COORD_W;
	localparam int unsigned ND_RESET = 102;
	localparam logic [THR_W-1:0] THR_SQ_RESET = THR_W'(ND_RESET * ND_RESET);
	localparam int unsigned OFIFO_DEPTH = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last_point;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] first_index;
		logic [IDX_OUT_W-1:0] end_index;
		logic                 last_cluster;
	} out_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	// one window cell: valid bit, point, the "far from every successor so far" flag and a has-successor flag
	typedef struct packed {
		logic   vld;
		logic   far;
		logic   succ;
		point_t pt;
	} cell_t;

	typedef enum logic [3:0] {
		PH_RUN   = 4'b0001,
		PH_FLUSH = 4'b0010,
		PH_FIN   = 4'b0100,
		PH_WRAP  = 4'b1000
	} phase_t;

	// squared distance strictly above squared threshold
	function automatic logic is_far(point_t a, point_t b, logic [THR_W-1:0] thr_sq);
		logic signed [COORD_W:0]     dx;
		logic signed [COORD_W:0]     dy;
		logic signed [2*COORD_W+1:0] sx;
		logic signed [2*COORD_W+1:0] sy;
		logic [THR_W:0]              d2;
		dx = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
		dy = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
		sx = dx * dx;
		sy = dy * dy;
		d2 = {1'b0, sx[THR_W-1:0]} + {1'b0, sy[THR_W-1:0]};
		return d2 > {1'b0, thr_sq};
	endfunction

endpackage

`default_nettype wire

/* rtl/sbs_cell.sv */
// one cell of the point window: holds a point and checks it against each new point
`default_nettype none

module sbs_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       cmp_en,
	input  wire sbs_pkg::point_t            cmp_pt,
	input  wire logic [sbs_pkg::THR_W-1:0]  thr_sq,
	input  wire sbs_pkg::cell_t             ins,
	output sbs_pkg::cell_t                  fwd
);

	sbs_pkg::cell_t st_q;

	// the content handed to the right neighbor carries this beat's compare
	always_comb begin
		fwd = st_q;
		if (cmp_en) begin
			fwd.far  = st_q.far & sbs_pkg::is_far(st_q.pt, cmp_pt, thr_sq);
			fwd.succ = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= ins;
		end
	end

endmodule

`default_nettype wire

/* rtl/sbs_out_fifo.sv */
// small result queue between the segmenter core and the output channel
`default_nettype none

module sbs_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sbs_pkg::out_beat_t push_data,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sbs_pkg::out_beat_t      out_data
);

	localparam int unsigned PW = $clog2(sbs_pkg::OFIFO_DEPTH);
	localparam int unsigned CW = $clog2(sbs_pkg::OFIFO_DEPTH + 1);

	sbs_pkg::out_beat_t mem_q [sbs_pkg::OFIFO_DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign full      = (cnt_q == CW'(sbs_pkg::OFIFO_DEPTH));
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(sbs_pkg::OFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(sbs_pkg::OFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/scan_breakpoint_segmenter.sv */
// a break after the first queues a result as its point leaves the window; the queue registers it
// throughput: one point per cycle in a scan unless the queue is full; cells check every new point
// scan end: after the final point the input stalls while the window flushes and one or two
// results (closing cluster, wrap part) are queued, longer while the output queue is full
// reset: scan state and window empty, threshold back to 102 (squared value 10404)
`default_nettype none

module scan_breakpoint_segmenter #(
	parameter int unsigned MAX_POINTS = 2048,
	parameter int unsigned LOOKAHEAD  = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [sbs_pkg::COORD_W-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire sbs_pkg::in_beat_t           in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output sbs_pkg::out_beat_t               out_data
);

	`include "scan_breakpoint_segmenter_defines.svh"

	localparam int unsigned IW = $clog2(MAX_POINTS);
	localparam int unsigned FW = $clog2(LOOKAHEAD);

	logic [sbs_pkg::THR_W-1:0] thr_sq_q;
	sbs_pkg::phase_t           phase_q;
	logic [FW-1:0]             flush_q;
	logic [IW-1:0]             cnt_q;
	logic [IW-1:0]             exit_idx_q;
	logic [IW-1:0]             fb_idx_q;
	logic [IW-1:0]             cl_start_q;
	logic                      seen_q;
	logic                      near_q;
	sbs_pkg::point_t           first_q;

	sbs_pkg::point_t           new_pt;
	sbs_pkg::cell_t            new_cell;
	sbs_pkg::cell_t            ins [LOOKAHEAD];
	sbs_pkg::cell_t            fwd [LOOKAHEAD];
	sbs_pkg::cell_t            ex;
	logic [LOOKAHEAD-1:0]      cell_vld;
	logic                      full;
	logic                      acc;
	logic                      last;
	logic                      adv;
	logic                      brk;
	logic                      push;
	logic                      wrap_split;
	logic                      scan_done;
	sbs_pkg::out_beat_t        push_data;

	assign in_stall = (phase_q != sbs_pkg::PH_RUN) || full;
	assign acc      = in_valid && !in_stall;
	assign last     = in_data.last_point || (cnt_q == IW'(MAX_POINTS - 1));
	assign adv      = acc || ((phase_q == sbs_pkg::PH_FLUSH) && !full);

	assign new_pt.x      = in_data.x;
	assign new_pt.y      = in_data.y;
	assign new_cell.vld  = acc;
	assign new_cell.far  = 1'b1;
	assign new_cell.succ = 1'b0;
	assign new_cell.pt   = new_pt;

	for (genvar g = 0; g < LOOKAHEAD; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign ins[g] = new_cell;
		end else begin : g_link
			assign ins[g] = fwd[g-1];
		end
		sbs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cmp_en (acc),
			.cmp_pt (new_pt),
			.thr_sq (thr_sq_q),
			.ins    (ins[g]),
			.fwd    (fwd[g])
		);
		assign cell_vld[g] = fwd[g].vld;
	end

	// the point leaving the oldest cell is a break if it had successors and stayed far from all of them
	assign ex  = fwd[LOOKAHEAD-1];
	assign brk = adv && ex.vld && ex.succ && ex.far;

	assign wrap_split = seen_q && !near_q;
	assign scan_done  = !full && (((phase_q == sbs_pkg::PH_FIN) && !wrap_split) ||
		(phase_q == sbs_pkg::PH_WRAP));

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		case (phase_q)
			sbs_pkg::PH_RUN, sbs_pkg::PH_FLUSH: begin
				push                   = brk && seen_q;
				push_data.first_index  = sbs_pkg::IDX_OUT_W'(cl_start_q);
				push_data.end_index    = sbs_pkg::IDX_OUT_W'(exit_idx_q);
				push_data.last_cluster = 1'b0;
			end
			sbs_pkg::PH_FIN: begin
				push = !full;
				if (!seen_q) begin
					push_data.first_index  = '0;
					push_data.end_index    = sbs_pkg::IDX_OUT_W'(cnt_q);
					push_data.last_cluster = 1'b1;
				end else if (near_q) begin
					// tail joins the head through index 0
					push_data.first_index  = sbs_pkg::IDX_OUT_W'(cl_start_q);
					push_data.end_index    = sbs_pkg::IDX_OUT_W'(fb_idx_q);
					push_data.last_cluster = 1'b1;
				end else begin
					push_data.first_index  = sbs_pkg::IDX_OUT_W'(cl_start_q);
					push_data.end_index    = sbs_pkg::IDX_OUT_W'(cnt_q);
					push_data.last_cluster = 1'b0;
				end
			end
			sbs_pkg::PH_WRAP: begin
				push                   = !full;
				push_data.first_index  = '0;
				push_data.end_index    = sbs_pkg::IDX_OUT_W'(fb_idx_q);
				push_data.last_cluster = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= sbs_pkg::THR_SQ_RESET;
		end else if (cfg_wr_en) begin
			thr_sq_q <= sbs_pkg::THR_W'(cfg_wr_data) * sbs_pkg::THR_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbs_pkg::PH_RUN;
			flush_q <= '0;
		end else begin
			case (phase_q)
				sbs_pkg::PH_RUN: begin
					if (acc && last) begin
						phase_q <= sbs_pkg::PH_FLUSH;
						flush_q <= FW'(LOOKAHEAD - 1);
					end
				end
				sbs_pkg::PH_FLUSH: begin
					if (!full) begin
						if (flush_q == '0) begin
							phase_q <= sbs_pkg::PH_FIN;
						end else begin
							flush_q <= flush_q - 1'b1;
						end
					end
				end
				sbs_pkg::PH_FIN: begin
					if (!full) begin
						phase_q <= wrap_split ? sbs_pkg::PH_WRAP : sbs_pkg::PH_RUN;
					end
				end
				sbs_pkg::PH_WRAP: begin
					if (!full) begin
						phase_q <= sbs_pkg::PH_RUN;
					end
				end
				default: begin
					phase_q <= sbs_pkg::PH_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			exit_idx_q <= '0;
			fb_idx_q   <= '0;
			cl_start_q <= '0;
			seen_q     <= 1'b0;
			near_q     <= 1'b0;
		end else if (scan_done) begin
			cnt_q      <= '0;
			exit_idx_q <= '0;
			fb_idx_q   <= '0;
			cl_start_q <= '0;
			seen_q     <= 1'b0;
		end else begin
			if (acc && !last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (acc && last) begin
				// point 0 itself is at distance zero from the first point
				near_q <= (cnt_q == '0) || !sbs_pkg::is_far(new_pt, first_q, thr_sq_q);
			end
			if (adv && ex.vld) begin
				exit_idx_q <= exit_idx_q + 1'b1;
			end
			if (brk) begin
				if (!seen_q) begin
					seen_q   <= 1'b1;
					fb_idx_q <= exit_idx_q;
				end
				cl_start_q <= exit_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (cnt_q == '0)) begin
			first_q <= new_pt;
		end
	end

	sbs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`SBS_ASSERT_NOW(a_push_room, push, !full, "result pushed into a full queue")
	`SBS_ASSERT_NEXT(a_last_flush, acc && last, phase_q == sbs_pkg::PH_FLUSH, "scan end without flush")
	`SBS_ASSERT_NOW(a_fin_empty, phase_q == sbs_pkg::PH_FIN, cell_vld == '0, "window not empty at scan close")

endmodule

`default_nettype wire

/* dv/tb.sv */
// testbench for the scan breakpoint segmenter: directed and random scans checked against an in-bench predictor
`default_nettype none

module tb;

	localparam int MAXP = 2048;
	localparam int LOOK = 4;
	localparam int HOLD_CYCLES = 250;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [sbs_pkg::COORD_W-1:0]   cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	sbs_pkg::in_beat_t             in_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	sbs_pkg::out_beat_t            out_data;

	bit                            quiet;
	bit                            hold_req;
	int unsigned                   settings;

	class cluster_board;
		sbs_pkg::out_beat_t          clusters_due[$];
		int unsigned                 errors;
		int unsigned                 matched;
		int unsigned                 points;
		int unsigned                 scans;
		logic [sbs_pkg::COORD_W-1:0] thr;
		sbs_pkg::point_t             win[LOOK+1];
		sbs_pkg::point_t             origin;
		int unsigned                 next_idx;
		int unsigned                 head_end;
		bit                          head_closed;
		int unsigned                 run_start;

		function new();
			thr = sbs_pkg::COORD_W'(sbs_pkg::ND_RESET);
			errors = 0;
			matched = 0;
			points = 0;
			scans = 0;
			restart();
		endfunction

		function void restart();
			foreach (win[i]) win[i] = '0;
			origin = '0;
			next_idx = 0;
			head_end = 0;
			head_closed = 1'b0;
			run_start = 0;
		endfunction

		function bit far_apart(sbs_pkg::point_t a, sbs_pkg::point_t b);
			longint dx;
			longint dy;
			dx = longint'(a.x) - longint'(b.x);
			dy = longint'(a.y) - longint'(b.y);
			return (dx * dx + dy * dy) > longint'(thr) * longint'(thr);
		endfunction

		// slot p is a break when far from every newer point still in the window
		function bit breaks_at(int p);
			if (p + 1 > LOOK) return 1'b0;
			for (int j = p + 1; j <= LOOK; j++) begin
				if (!far_apart(win[p], win[j])) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void add_cluster(int unsigned s, int unsigned e, bit fin);
			sbs_pkg::out_beat_t c;
			c.first_index = sbs_pkg::IDX_OUT_W'(s);
			c.end_index = sbs_pkg::IDX_OUT_W'(e);
			c.last_cluster = fin;
			clusters_due = {clusters_due, c};
		endfunction

		function void on_break(int unsigned idx);
			if (!head_closed) begin
				head_closed = 1'b1;
				head_end = idx;
			end else begin
				add_cluster(run_start, idx, 1'b0);
			end
			run_start = idx + 1;
		endfunction

		function void note_point(sbs_pkg::in_beat_t b);
			int unsigned     k;
			sbs_pkg::point_t pt;
			bit              fin;
			int              p;
			k = next_idx;
			pt.x = b.x;
			pt.y = b.y;
			fin = b.last_point || (k >= MAXP - 1);
			points++;
			for (int i = 0; i < LOOK; i++) win[i] = win[i+1];
			win[LOOK] = pt;
			if (k == 0) origin = pt;
			if (k >= LOOK && breaks_at(0)) on_break(k - LOOK);
			if (!fin) begin
				next_idx = k + 1;
				return;
			end
			// scan end: the remaining candidates are confirmed without full lookahead
			p = (k >= LOOK) ? 1 : LOOK - int'(k);
			for (; p < LOOK; p++) begin
				if (breaks_at(p)) on_break(k - (LOOK - p));
			end
			if (!head_closed) begin
				add_cluster(0, k, 1'b1);
			end else if (!far_apart(pt, origin)) begin
				add_cluster(run_start, head_end, 1'b1);
			end else begin
				add_cluster(run_start, k, 1'b0);
				add_cluster(0, head_end, 1'b1);
			end
			scans++;
			restart();
		endfunction

		function void check_cluster(sbs_pkg::out_beat_t got);
			sbs_pkg::out_beat_t want;
			if (clusters_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected cluster: start %0d end %0d last %0d",
						got.first_index, got.end_index, got.last_cluster);
				return;
			end
			want = clusters_due.pop_front();
			if (got.first_index !== want.first_index || got.end_index !== want.end_index ||
					got.last_cluster !== want.last_cluster) begin
				errors++;
				if (errors <= 10)
					$display({"cluster mismatch: expected start %0d end %0d last %0d, ",
						"got start %0d end %0d last %0d"},
						want.first_index, want.end_index, want.last_cluster,
						got.first_index, got.end_index, got.last_cluster);
			end else begin
				matched++;
			end
		endfunction
	endclass

	cluster_board sb;

	scan_breakpoint_segmenter #(
		.MAX_POINTS(MAXP),
		.LOOKAHEAD(LOOK)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [sbs_pkg::COORD_W-1:0] sat16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return sbs_pkg::COORD_W'(v);
	endfunction

	function automatic sbs_pkg::point_t nudge(sbs_pkg::point_t p, int half);
		sbs_pkg::point_t q;
		q.x = sat16(longint'(p.x) + int'($urandom_range(0, 2 * half)) - half);
		q.y = sat16(longint'(p.y) + int'($urandom_range(0, 2 * half)) - half);
		return q;
	endfunction

	function automatic sbs_pkg::in_beat_t mk(int x, int y, bit fin);
		sbs_pkg::in_beat_t b;
		b.x = sbs_pkg::COORD_W'(x);
		b.y = sbs_pkg::COORD_W'(y);
		b.last_point = fin;
		return b;
	endfunction

	task automatic send_point(sbs_pkg::in_beat_t b);
		int gap;
		int r;
		if (quiet) begin
			gap = 0;
		end else begin
			r = $urandom_range(99);
			gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(12, 40);
		end
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		sb.note_point(b);
	endtask

	// short hops inside the threshold at near_pct percent, else jumps, boundary steps or corner swaps
	task automatic send_scan(int n, int near_pct, bit wrap_close, bit mark_end);
		sbs_pkg::point_t   cur;
		sbs_pkg::point_t   first;
		int                half;
		int                r;
		longint            d;
		sbs_pkg::in_beat_t b;
		half = int'(sb.thr) / 2;
		cur.x = sbs_pkg::COORD_W'($urandom);
		cur.y = sbs_pkg::COORD_W'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				r = $urandom_range(99);
				if (r < near_pct) begin
					cur = nudge(cur, half);
				end else if ($urandom_range(2) == 0) begin
					d = longint'(sb.thr) + $urandom_range(1);
					cur.x = sat16($urandom_range(1) ? longint'(cur.x) + d : longint'(cur.x) - d);
				end else if ($urandom_range(1) == 0) begin
					cur.x = cur.x[sbs_pkg::COORD_W-1] ? 16'sd32767 : -16'sd32768;
					cur.y = cur.y[sbs_pkg::COORD_W-1] ? 16'sd32767 : -16'sd32768;
				end else begin
					cur.x = sbs_pkg::COORD_W'($urandom);
					cur.y = sbs_pkg::COORD_W'($urandom);
				end
			end else begin
				first = cur;
			end
			if (i == n - 1 && i > 0 && wrap_close) cur = nudge(first, half);
			b.x = cur.x;
			b.y = cur.y;
			b.last_point = mark_end && (i == n - 1);
			send_point(b);
		end
	endtask

	task automatic set_threshold(logic [sbs_pkg::COORD_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.clusters_due.size() != 0) @(posedge clk);
		repeat (LOOK + 6) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.thr = v;
		settings++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_cluster(out_data);
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int unsigned left;
		int          r;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				left = HOLD_CYCLES;
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 65) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
				end
			end
		end
	end

	initial begin : stim
		int unsigned                 base;
		int                          n;
		logic [sbs_pkg::COORD_W-1:0] v;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// single point, then two far extremes
		send_point(mk(-32768, 32767, 1'b1));
		send_point(mk(32767, -32768, 1'b0));
		send_point(mk(-32768, 32767, 1'b1));
		// no break at all
		send_point(mk(0, 0, 1'b0));
		send_point(mk(50, 50, 1'b0));
		send_point(mk(100, 0, 1'b0));
		send_point(mk(0, 0, 1'b1));
		// distance exactly at the threshold is near, one more is far
		send_point(mk(0, 0, 1'b0));
		send_point(mk(102, 0, 1'b0));
		send_point(mk(205, 0, 1'b1));
		// tail closes back onto the head: wrapped cluster
		send_point(mk(0, 0, 1'b0));
		send_point(mk(10, 0, 1'b0));
		send_point(mk(5000, 5000, 1'b0));
		send_point(mk(5010, 5000, 1'b0));
		send_point(mk(-20000, -20000, 1'b0));
		send_point(mk(-20010, -20000, 1'b0));
		send_point(mk(5, 5, 1'b1));
		// corner to corner
		send_point(mk(-32768, -32768, 1'b0));
		send_point(mk(32767, 32767, 1'b0));
		send_point(mk(-32768, 32767, 1'b0));
		send_point(mk(32767, -32768, 1'b0));
		send_point(mk(-32768, -32768, 1'b1));

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: v = '0;
				1: v = '1;
				2: v = sbs_pkg::COORD_W'($urandom_range(200, 3000));
				3: v = sbs_pkg::COORD_W'($urandom);
				default: v = sbs_pkg::COORD_W'(sbs_pkg::ND_RESET);
			endcase
			set_threshold(v);
			quiet = (ph == 3);
			if (ph == 2) begin
				// receiver holds off while a run of far points piles up results
				hold_req = 1'b1;
				quiet = 1'b1;
				send_scan(20, 0, 1'b0, 1'b1);
				quiet = 1'b0;
			end
			base = sb.points;
			while (sb.points - base < 10) begin
				n = ($urandom_range(5) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
				if ($urandom_range(4) == 0)
					send_scan(n, 0, $urandom_range(1), 1'b1);
				else
					send_scan(n, $urandom_range(50, 90), $urandom_range(1), 1'b1);
			end
			quiet = 1'b0;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.clusters_due.size() != 0) @(posedge clk);
		repeat (LOOK + 16) @(posedge clk);

		$display("covered %0d scans, %0d points, %0d threshold writes incl. both extremes",
			sb.scans, sb.points, settings);
		$display("%0d clusters matched; one %0d-cycle output hold-off with the input backed up",
			sb.matched, HOLD_CYCLES);
		if (sb.clusters_due.size() != 0)
			$display("%0d expected clusters never arrived", sb.clusters_due.size());
		if (sb.errors == 0 && sb.clusters_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin : watchdog
		#7200000;
		$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/sbs_pkg.sv
rtl/sbs_cell.sv
rtl/sbs_out_fifo.sv
rtl/scan_breakpoint_segmenter.sv
dv/tb.sv
